/* src/ptpd_pkg.sv */
// Shared constants and types for the point transform / perspective divide block.
// No dependencies.
package ptpd_pkg;

   localparam int NUM_REGS    = 8;
   localparam int REG_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int HALF_W      = 32;
   localparam int COORD_PORT_W = 32;
   localparam int NUM_COLS    = 4;

   // status that travels with each divider result
   typedef struct packed {
      logic sat;
      logic zero;
   } div_flags_type;

endpackage

/* src/point_transform_perspective_divide.sv */
// Homogeneous 4x4 point transform with perspective divide, Q(CW-FB).FB fixed point.
// Uses ptpd_pkg, ptpd_mac_lane (one per matrix column), ptpd_div_lane (one per x/y/z).
// Accepts one point per clock and returns one result per clock while rsp_ready holds.
// Each point passes the product and sum registers of the column multiply-add lanes,
// then the sign, overflow-test and quotient-bit registers of the pipelined divider and
// its saturation register, and last the result register. A stall on rsp_ready
// holds the whole pipeline, so req_ready drops in the same cycle. The matrix resets to
// identity; w equal to zero gives zero coordinates with rsp_w_zero set.
module point_transform_perspective_divide #(
   parameter int COORD_WIDTH   = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [ptpd_pkg::COORD_PORT_W-1:0] req_in_x,
   input  logic signed [ptpd_pkg::COORD_PORT_W-1:0] req_in_y,
   input  logic signed [ptpd_pkg::COORD_PORT_W-1:0] req_in_z,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [ptpd_pkg::COORD_PORT_W-1:0] rsp_out_x,
   output logic signed [ptpd_pkg::COORD_PORT_W-1:0] rsp_out_y,
   output logic signed [ptpd_pkg::COORD_PORT_W-1:0] rsp_out_z,
   output logic                                     rsp_w_zero,
   output logic                                     rsp_saturated,
   input  logic                                     csr_we,
   input  logic [ptpd_pkg::REG_IDX_W-1:0]           csr_index,
   input  logic [ptpd_pkg::CSR_DATA_W-1:0]          csr_data
);
   import ptpd_pkg::*;

   localparam int CW  = COORD_WIDTH;
   localparam int FB  = FRACTION_BITS;
   localparam int HW  = 2 * CW - FB + 2;
   localparam int PIPE = CW + 5;
   localparam logic [HALF_W-1:0] ONE_FIX = HALF_W'(1) << FB;
   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

   logic [CSR_DATA_W-1:0] mat_ff [0:NUM_REGS-1];
   logic [PIPE-1:0]       vld_ff;
   logic                  advance;

   logic signed [CW-1:0] px, py, pz;
   logic signed [HW-1:0] h [0:NUM_COLS-1];
   logic signed [CW-1:0] q [0:2];
   div_flags_type        fl [0:2];

   logic                           rsp_valid_ff;
   logic signed [COORD_PORT_W-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic                           w_zero_ff, sat_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_REGS; k++) begin
            for (int hf = 0; hf < 2; hf++) begin
               mat_ff[k][hf*HALF_W +: HALF_W] <=
                  ((k / 2) == ((k % 2) * 2 + hf)) ? ONE_FIX : '0;
            end
         end
      end else if (csr_we) begin
         mat_ff[csr_index] <= csr_data;
      end
   end

   assign px = req_in_x[CW-1:0];
   assign py = req_in_y[CW-1:0];
   assign pz = req_in_z[CW-1:0];

   for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
      ptpd_mac_lane #(.CW(CW), .FB(FB)) u_mac (
         .clock   (clock),
         .advance (advance),
         .x       (px),
         .y       (py),
         .z       (pz),
         .e0      (mat_ff[0 + c/2][(c%2)*HALF_W +: CW]),
         .e1      (mat_ff[2 + c/2][(c%2)*HALF_W +: CW]),
         .e2      (mat_ff[4 + c/2][(c%2)*HALF_W +: CW]),
         .e3      (mat_ff[6 + c/2][(c%2)*HALF_W +: CW]),
         .h       (h[c])
      );
   end

   for (genvar i = 0; i < 3; i++) begin : g_div
      ptpd_div_lane #(.CW(CW), .FB(FB)) u_div (
         .clock   (clock),
         .advance (advance),
         .num     (h[i]),
         .den     (h[NUM_COLS-1]),
         .quot    (q[i]),
         .flags   (fl[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= {vld_ff[PIPE-2:0], req_valid};
         rsp_valid_ff <= vld_ff[PIPE-1];
      end
   end

   // merge the three lanes; w is shared so any lane's zero flag will do
   always_ff @(posedge clock) begin
      if (advance) begin
         if (fl[0].zero) begin
            out_x_ff  <= '0;
            out_y_ff  <= '0;
            out_z_ff  <= '0;
            w_zero_ff <= 1'b1;
            sat_ff    <= 1'b0;
         end else begin
            out_x_ff  <= COORD_PORT_W'(q[0]);
            out_y_ff  <= COORD_PORT_W'(q[1]);
            out_z_ff  <= COORD_PORT_W'(q[2]);
            w_zero_ff <= 1'b0;
            sat_ff    <= fl[0].sat | fl[1].sat | fl[2].sat;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = out_x_ff;
   assign rsp_out_y     = out_y_ff;
   assign rsp_out_z     = out_z_ff;
   assign rsp_w_zero    = w_zero_ff;
   assign rsp_saturated = sat_ff;

   a_wzero_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_w_zero |-> rsp_out_x == '0 && rsp_out_y == '0 &&
                                  rsp_out_z == '0 && !rsp_saturated)
      else $error("w_zero transaction with nonzero payload");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted while pipeline stalled");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_out_x == COORD_PORT_W'(CMAX) || rsp_out_x == COORD_PORT_W'(CMIN) ||
         rsp_out_y == COORD_PORT_W'(CMAX) || rsp_out_y == COORD_PORT_W'(CMIN) ||
         rsp_out_z == COORD_PORT_W'(CMAX) || rsp_out_z == COORD_PORT_W'(CMIN))
      else $error("saturated flag without a clipped coordinate");

endmodule

/* src/ptpd_mac_lane.sv */
// One matrix column: three coordinate products, floor rescale and sum with row 3.
// Imports ptpd_pkg, though nothing from it is used.
module ptpd_mac_lane #(
   parameter int CW = 32,
   parameter int FB = 16
) (
   input  logic                     clock,
   input  logic                     advance,
   input  logic signed [CW-1:0]     x,
   input  logic signed [CW-1:0]     y,
   input  logic signed [CW-1:0]     z,
   input  logic signed [CW-1:0]     e0,
   input  logic signed [CW-1:0]     e1,
   input  logic signed [CW-1:0]     e2,
   input  logic signed [CW-1:0]     e3,
   output logic signed [2*CW-FB+1:0] h
);
   import ptpd_pkg::*;

   localparam int PW = 2 * CW;
   localparam int SW = PW - FB;
   localparam int HW = 2 * CW - FB + 2;

   logic signed [PW-1:0] prod0_ff, prod1_ff, prod2_ff;
   logic signed [CW-1:0] bias_ff;
   logic signed [SW-1:0] r0, r1, r2;
   logic signed [HW-1:0] h_in, h_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         prod0_ff <= PW'(x) * PW'(e0);
         prod1_ff <= PW'(y) * PW'(e1);
         prod2_ff <= PW'(z) * PW'(e2);
         bias_ff  <= e3;
         h_ff     <= h_in;
      end
   end

   // dropping the low bits of a two's complement product rounds toward minus infinity
   assign r0 = prod0_ff[PW-1:FB];
   assign r1 = prod1_ff[PW-1:FB];
   assign r2 = prod2_ff[PW-1:FB];

   assign h_in = HW'(r0) + HW'(r1) + HW'(r2) + HW'(bias_ff);
   assign h    = h_ff;

endmodule

/* src/ptpd_div_lane.sv */
// Pipelined restoring divider: (num << FB) / den, truncated, saturated to CW bits.
// Uses ptpd_pkg for the result flag struct.
module ptpd_div_lane #(
   parameter int CW = 32,
   parameter int FB = 16
) (
   input  logic                      clock,
   input  logic                      advance,
   input  logic signed [2*CW-FB+1:0] num,
   input  logic signed [2*CW-FB+1:0] den,
   output logic signed [CW-1:0]      quot,
   output ptpd_pkg::div_flags_type   flags
);
   import ptpd_pkg::*;

   localparam int HW = 2 * CW - FB + 2;
   localparam int DW = HW + ((CW > FB) ? CW : FB) + 1;

   logic          neg0_ff, zero0_ff;
   logic [HW-1:0] a0_ff, d0_ff;

   logic [DW-1:0] rem_ff  [0:CW];
   logic [CW-1:0] quo_ff  [0:CW];
   logic [HW-1:0] d_ff    [0:CW];
   logic          neg_ff  [0:CW];
   logic          ovf_ff  [0:CW];
   logic          zero_ff [0:CW];

   logic signed [CW-1:0] quot_ff;
   div_flags_type        flags_ff;

   logic [CW-1:0] limit, q_fin, q_mag;
   logic          sat_fin;

   // stage: sign and magnitudes
   always_ff @(posedge clock) begin
      if (advance) begin
         neg0_ff  <= num[HW-1] ^ den[HW-1];
         zero0_ff <= (den == '0);
         a0_ff    <= num[HW-1] ? HW'(-num) : HW'(num);
         d0_ff    <= den[HW-1] ? HW'(-den) : HW'(den);
      end
   end

   // stage: scaled dividend and overflow test on the full quotient
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= DW'(a0_ff) << FB;
         quo_ff[0]  <= '0;
         d_ff[0]    <= d0_ff;
         neg_ff[0]  <= neg0_ff;
         zero_ff[0] <= zero0_ff;
         ovf_ff[0]  <= (DW'(a0_ff) << FB) >= (DW'(d0_ff) << CW);
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar j = 0; j < CW; j++) begin : g_iter
      logic [DW-1:0] trial;
      logic          take;
      assign trial = DW'(d_ff[j]) << (CW - 1 - j);
      assign take  = rem_ff[j] >= trial;
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j+1]  <= take ? rem_ff[j] - trial : rem_ff[j];
            quo_ff[j+1]  <= {quo_ff[j][CW-2:0], take};
            d_ff[j+1]    <= d_ff[j];
            neg_ff[j+1]  <= neg_ff[j];
            ovf_ff[j+1]  <= ovf_ff[j];
            zero_ff[j+1] <= zero_ff[j];
         end
      end
   end

   always_comb begin
      limit   = neg_ff[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      q_fin   = quo_ff[CW];
      sat_fin = ovf_ff[CW] || (q_fin > limit);
      q_mag   = sat_fin ? limit : q_fin;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quot_ff       <= neg_ff[CW] ? -$signed(q_mag) : $signed(q_mag);
         flags_ff.sat  <= sat_fin;
         flags_ff.zero <= zero_ff[CW];
      end
   end

   assign quot  = quot_ff;
   assign flags = flags_ff;

endmodule
